// ===== rtl/jitter_buffer_sorted_queue_defines.svh =====
// assertion macros for the jitter buffer sorted queue
// used by the top level; expects clock and reset in scope
`ifndef JITTER_BUFFER_SORTED_QUEUE_DEFINES_SVH
`define JITTER_BUFFER_SORTED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define JBSQ_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("jbsq assertion failed");

// consequent holds in the same cycle as the antecedent
`define JBSQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jbsq assertion failed");

// consequent holds in the cycle after the antecedent
`define JBSQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jbsq assertion failed");

`else

`define JBSQ_ASSERT_ALWAYS(label, expr)
`define JBSQ_ASSERT_SAME(label, ante, cons)
`define JBSQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/jbsq_pkg.sv =====
// shared types and constants for the jitter buffer sorted queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jbsq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned HANDLE_BITS   = 16;
   localparam int unsigned LENGTH_BITS   = 16;
   localparam int unsigned TIME_BITS     = 32;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]             operation;
      logic [HANDLE_BITS-1:0] packet_handle;
      logic [LENGTH_BITS-1:0] packet_length;
      logic [TIME_BITS-1:0]   packet_time;
   } req_type;

   typedef struct packed {
      logic                   was_empty;
      logic [HANDLE_BITS-1:0] out_handle;
      logic [LENGTH_BITS-1:0] out_length;
      logic [TIME_BITS-1:0]   out_time;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]   stamp;
      logic [HANDLE_BITS-1:0] handle;
      logic [LENGTH_BITS-1:0] length;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic drop;
      logic insert;
      logic pop;
      logic clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       len_zero;
      logic       full;
      logic       empty;
      logic       rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/jbsq_ctrl.sv =====
// request sequencer for the jitter buffer sorted queue
// depends on jbsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module jbsq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire jbsq_pkg::status_type status,
   output jbsq_pkg::cmd_type        cmd
);
   import jbsq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_EXEC   = 3'b010,
      S_INSERT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.op)
               OP_PUSH: begin
                  if (status.len_zero) begin
                     state_in = S_IDLE;
                  end else if (status.full) begin
                     // make room at the front, insert next cycle
                     cmd.drop = 1'b1;
                     state_in = S_INSERT;
                  end else begin
                     cmd.insert = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               OP_POP: begin
                  // wait until the result slot can take a new result
                  if (!status.rsp_busy) begin
                     cmd.pop  = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/jbsq_datapath.sv =====
// sorted cell array, request register and result register
// depends on jbsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module jbsq_datapath #(
   parameter int unsigned DEPTH = jbsq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jbsq_pkg::req_type   req_data,
   input  wire jbsq_pkg::cmd_type   cmd,
   output jbsq_pkg::status_type     status,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output jbsq_pkg::rsp_type        rsp_data
);
   import jbsq_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   req_type              req_ff;
   entry_type            entry_ff [DEPTH];
   entry_type            entry_in [DEPTH];
   entry_type            entry_prev [DEPTH];
   entry_type            entry_next [DEPTH];
   logic [DEPTH-1:0]     lt;
   logic [DEPTH-1:0]     lt_prev;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   entry_type            new_entry;
   logic                 empty;
   logic                 shift;

   assign empty     = (count_ff == '0);
   assign shift     = cmd.drop | (cmd.pop & ~empty);
   assign new_entry = '{stamp:  req_ff.packet_time,
                        handle: req_ff.packet_handle,
                        length: req_ff.packet_length};

   assign status.op       = req_ff.operation;
   assign status.len_zero = (req_ff.packet_length == '0);
   assign status.full     = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty    = empty;
   assign status.rsp_busy = rsp_valid_ff & ~rsp_ready;

   // each cell compares its own key against the new one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign lt[i] = (CNT_BITS'(i) < count_ff) && (entry_ff[i].stamp < req_ff.packet_time);

      if (i == 0) begin : g_first
         assign lt_prev[i]    = 1'b1;
         assign entry_prev[i] = entry_ff[i];
      end else begin : g_mid
         assign lt_prev[i]    = lt[i-1];
         assign entry_prev[i] = entry_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign entry_next[i] = entry_ff[i];
      end else begin : g_inner
         assign entry_next[i] = entry_ff[i+1];
      end

      always_comb begin
         entry_in[i] = entry_ff[i];
         if (cmd.insert) begin
            if (!lt[i]) begin
               entry_in[i] = lt_prev[i] ? new_entry : entry_prev[i];
            end
         end else if (shift) begin
            entry_in[i] = entry_next[i];
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (shift) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         if (empty) begin
            rsp_in = '{was_empty: 1'b1, out_handle: '0, out_length: '0, out_time: '0};
         end else begin
            rsp_in = '{was_empty:  1'b0,
                       out_handle: entry_ff[0].handle,
                       out_length: entry_ff[0].length,
                       out_time:   entry_ff[0].stamp};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/jitter_buffer_sorted_queue.sv =====
// top level of the jitter buffer sorted queue
// depends on jbsq_pkg, jbsq_ctrl, jbsq_datapath and the defines header
//
// usage:
// - req channel carries one request: push, pop or clear, with a packet
//   descriptor (handle, length, timestamp) used by push only
// - rsp channel returns one result per pop: the front descriptor, or
//   was_empty set with all other fields zero
// - descriptors stay sorted by ascending timestamp; a new one goes ahead of
//   equal timestamps, a zero-length push is dropped, a push into a full
//   buffer first discards the front entry
// - each request is first loaded into the request register on the accept edge,
//   then the execute edge runs one step on the cell array; a push into a full
//   buffer runs a discard step, then an insert step
// - every cell compares its key in parallel, so depth does not change timing
// - pop result shows on rsp_valid once the execute edge has passed, and sits
//   in an output register; new requests are taken while it waits
// - if rsp is stalled, a second pop holds in the execute step until the
//   result register frees; pushes and clears go on unaffected
// - synchronous reset empties the buffer and drops any pending result;
//   no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "jitter_buffer_sorted_queue_defines.svh"

module jitter_buffer_sorted_queue #(
   parameter int unsigned DEPTH = jbsq_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jbsq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output jbsq_pkg::rsp_type      rsp_data
);
   import jbsq_pkg::*;

   // command and status between sequencer and cell array
   cmd_type    cmd;
   status_type status;

   jbsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   jbsq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a new result only ever comes from a pop step
   `JBSQ_ASSERT_SAME(a_rsp_from_pop, $rose(rsp_valid), $past(cmd.pop))
   // no array step runs while a request is being taken
   `JBSQ_ASSERT_SAME(a_idle_no_cmd, req_ready, !(cmd.drop || cmd.insert || cmd.pop || cmd.clear))
   // discarding the front for a full push is always followed by the insert
   `JBSQ_ASSERT_NEXT(a_drop_then_insert, cmd.drop, cmd.insert)
   // a pop never overwrites a result still waiting on the receiver
   `JBSQ_ASSERT_SAME(a_pop_slot_free, cmd.pop, !(rsp_valid && !rsp_ready))
   // fill level is consistent
   `JBSQ_ASSERT_ALWAYS(a_full_empty, !(status.full && status.empty))

endmodule

`default_nettype wire
